>>> hdl/cppt_pkg.sv
package cppt_pkg;

  localparam int COUNT_BITS  = 5;
  localparam int CNT_BITS    = COUNT_BITS + 1;
  localparam int SLOT_BITS   = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = COUNT_BITS'(3);
  localparam logic [COUNT_BITS-1:0] MIN_VERTICES       = COUNT_BITS'(3);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  typedef enum logic {
    OP_WRITE,
    OP_TEST
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic                 slot_ok;
    logic [SLOT_BITS-1:0] slot;
  } cmd_tag_t;

  localparam int TAG_BITS = $bits(cmd_tag_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

endpackage

>>> hdl/cppt_if.sv
interface cppt_in_if #(
  parameter int COORD_BITS = 16
) ();
  import cppt_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [SLOT_BITS-1:0]         vertex_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (
    output valid, command, vertex_index, coord_x, coord_y, coord_z,
    input  ready
  );

  modport sink (
    input  valid, command, vertex_index, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

interface cppt_out_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );

  modport sink (
    input  valid, inside_res,
    output ready
  );
endinterface

>>> hdl/cppt_front.sv
module cppt_front #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  cppt_in_if.sink                                       items,
  output logic                                          push,
  output logic [cppt_pkg::TAG_BITS+3*COORD_BITS-1:0]    push_data,
  input  logic                                          push_ready
);
  import cppt_pkg::*;

  cmd_tag_t tag;

  always_comb begin
    tag.op      = OP_WRITE;
    tag.slot    = items.vertex_index;
    tag.slot_ok = int'(items.vertex_index) < MAX_VERTICES;
    unique case (items.command)
      CMD_WRITE: tag.op = OP_WRITE;
      CMD_TEST:  tag.op = OP_TEST;
    endcase
  end

  assign items.ready = push_ready;
  assign push        = items.valid && push_ready;
  assign push_data   = {tag, items.coord_x, items.coord_y, items.coord_z};

endmodule

>>> hdl/cppt_queue.sv
module cppt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);
  import cppt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

>>> hdl/cppt_term.sv
module cppt_term #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic [3*COORD_BITS-1:0] p0,
  input  logic [3*COORD_BITS-1:0] p1,
  input  logic [3*COORD_BITS-1:0] p2,
  input  logic [3*COORD_BITS-1:0] pt,
  output logic                    busy,
  output logic                    out_vld,
  output logic                    out_pos
);

  localparam int CB   = COORD_BITS;
  localparam int VW   = 3 * CB;
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int XW   = PW + 1;
  localparam int HL   = (XW + 1) / 2;
  localparam int HH   = XW - HL;
  localparam int MW   = XW + 1;
  localparam int DOTW = 2 * XW + 2;

  logic signed [CB-1:0]   a0 [3];
  logic signed [CB-1:0]   a1 [3];
  logic signed [CB-1:0]   a2 [3];
  logic signed [CB-1:0]   ap [3];

  logic signed [DW-1:0]   d02 [3];
  logic signed [DW-1:0]   d01 [3];
  logic signed [DW-1:0]   d0p [3];
  logic signed [PW-1:0]   m1a [3];
  logic signed [PW-1:0]   m1b [3];
  logic signed [PW-1:0]   m2a [3];
  logic signed [PW-1:0]   m2b [3];
  logic signed [XW-1:0]   x1 [3];
  logic signed [XW-1:0]   x2 [3];
  logic [2*HL-1:0]        pll [3];
  logic signed [MW-1:0]   plh [3];
  logic signed [MW-1:0]   phl [3];
  logic signed [2*HH-1:0] phh [3];
  logic signed [DOTW-1:0] prod [3];
  logic signed [DOTW-1:0] dot;

  logic v1, v2, v3, v4, v5;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a0[k] = p0[VW-1-k*CB -: CB];
      a1[k] = p1[VW-1-k*CB -: CB];
      a2[k] = p2[VW-1-k*CB -: CB];
      ap[k] = pt[VW-1-k*CB -: CB];
    end
  end

  assign dot = prod[0] + prod[1] + prod[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      v5      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      v5      <= v4;
      out_vld <= v5;
    end
  end

  always_ff @(posedge clk) begin
    int j1;
    int j2;
    for (int k = 0; k < 3; k++) begin
      j1 = (k == 2) ? 0 : k + 1;
      j2 = (k == 0) ? 2 : k - 1;

      d02[k] <= DW'(a2[k]) - DW'(a0[k]);
      d01[k] <= DW'(a1[k]) - DW'(a0[k]);
      d0p[k] <= DW'(ap[k]) - DW'(a0[k]);

      m1a[k] <= d02[j1] * d01[j2];
      m1b[k] <= d02[j2] * d01[j1];
      m2a[k] <= d01[j1] * d0p[j2];
      m2b[k] <= d01[j2] * d0p[j1];

      x1[k] <= XW'(m1a[k]) - XW'(m1b[k]);
      x2[k] <= XW'(m2a[k]) - XW'(m2b[k]);

      pll[k] <= x1[k][HL-1:0] * x2[k][HL-1:0];
      plh[k] <= $signed({1'b0, x1[k][HL-1:0]}) * $signed(x2[k][XW-1:HL]);
      phl[k] <= $signed(x1[k][XW-1:HL]) * $signed({1'b0, x2[k][HL-1:0]});
      phh[k] <= $signed(x1[k][XW-1:HL]) * $signed(x2[k][XW-1:HL]);

      prod[k] <= (DOTW'(phh[k]) << (2 * HL))
               + ((DOTW'(plh[k]) + DOTW'(phl[k])) << HL)
               + DOTW'(pll[k]);
    end
    out_pos <= !dot[DOTW-1] && (dot != '0);
  end

  assign busy = v1 || v2 || v3 || v4 || v5 || out_vld;

endmodule

>>> hdl/cppt_back.sv
module cppt_back #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [cppt_pkg::COUNT_BITS-1:0]            vertex_count,
  input  logic                                       q_valid,
  output logic                                       q_ready,
  input  logic [cppt_pkg::TAG_BITS+3*COORD_BITS-1:0] q_data,
  cppt_out_if.source                                 results
);
  import cppt_pkg::*;

  localparam int VW = 3 * COORD_BITS;
  localparam int EW = TAG_BITS + VW;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  back_state_t state, state_next;

  cmd_tag_t               tag;
  logic [VW-1:0]          coords;
  logic [COUNT_BITS-1:0]  n_eff;
  logic [CNT_BITS-1:0]    n_wide;
  logic [CNT_BITS-1:0]    rd_cnt;
  logic [CNT_BITS-1:0]    addr_cnt;
  logic [AW+CNT_BITS-1:0] rd_addr_wide;
  logic [AW+SLOT_BITS-1:0] wr_addr_wide;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   last_rd;

  logic                   store_we;
  logic                   start_walk;
  logic                   issue;
  logic                   load_res;
  logic                   res_free;

  logic [VW-1:0]          store [MAX_VERTICES];
  logic [VW-1:0]          rdata;
  logic [VW-1:0]          w0, w1, w2;
  logic [VW-1:0]          pt;
  logic                   rd_vld;
  logic                   rd_term;
  logic                   win_vld;
  logic                   outside;
  logic                   res_valid;
  logic                   res_inside;

  logic                   term_busy;
  logic                   pos_vld;
  logic                   pos;

  assign tag    = cmd_tag_t'(q_data[EW-1 -: TAG_BITS]);
  assign coords = q_data[VW-1:0];

  always_comb begin
    if (vertex_count < MIN_VERTICES) begin
      n_eff = MIN_VERTICES;
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_eff = COUNT_BITS'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  assign n_wide       = {1'b0, n_eff};
  assign last_rd      = rd_cnt == n_wide + 1'b1;
  assign addr_cnt     = (rd_cnt < n_wide) ? rd_cnt : rd_cnt - n_wide;
  assign rd_addr_wide = (AW+CNT_BITS)'(addr_cnt);
  assign rd_addr      = rd_addr_wide[AW-1:0];
  assign wr_addr_wide = (AW+SLOT_BITS)'(tag.slot);
  assign wr_addr      = wr_addr_wide[AW-1:0];
  assign res_free     = !res_valid || results.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && tag.op == OP_TEST) state_next = BK_WALK;
      end
      BK_WALK: begin
        if (last_rd) state_next = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (!rd_vld && !win_vld && !term_busy) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (res_free) state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_ready    = 1'b0;
    store_we   = 1'b0;
    start_walk = 1'b0;
    issue      = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          start_walk = tag.op == OP_TEST;
          store_we   = tag.op == OP_WRITE && tag.slot_ok;
        end
      end
      BK_WALK:  issue    = 1'b1;
      BK_DRAIN: issue    = 1'b0;
      BK_DONE:  load_res = res_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_cnt    <= '0;
      rd_vld    <= 1'b0;
      rd_term   <= 1'b0;
      win_vld   <= 1'b0;
      outside   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= issue;
      rd_term <= issue && (rd_cnt >= CNT_BITS'(2));
      win_vld <= rd_vld && rd_term;
      if (start_walk) begin
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (start_walk) begin
        outside <= 1'b0;
      end else if (pos_vld && pos) begin
        outside <= 1'b1;
      end
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store[wr_addr] <= coords;
    rdata <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (start_walk) pt <= coords;
    if (rd_vld) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= rdata;
    end
    if (load_res) res_inside <= !outside;
  end

  cppt_term #(
    .COORD_BITS (COORD_BITS)
  ) u_term (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (win_vld),
    .p0      (w0),
    .p1      (w1),
    .p2      (w2),
    .pt      (pt),
    .busy    (term_busy),
    .out_vld (pos_vld),
    .out_pos (pos)
  );

  assign results.valid      = res_valid;
  assign results.inside_res = res_inside;

endmodule

>>> hdl/convex_polygon_point_test_unit.sv
// Point-in-convex-polygon test on a stored 3D polygon. A vertex write (command 0) stores
// one vertex in the slot given by vertex_index and returns nothing; a point test (command 1)
// returns one inside_res bit, 1 when no edge term ((p2-p0)x(p1-p0)).((p1-p0)x(pt-p0)) is
// positive, so points on an edge count as inside. Coordinates are signed COORD_BITS-bit
// fixed point and all products are exact. vertex_count is clamped to 3..MAX_VERTICES and
// may only be written while the block is idle. Transactions enter a four-deep queue and
// run in order: a vertex write is stored straight from the queue head, and a point test holds
// the back end for a walk over the n vertices in use, set by the vertex store's single read
// port, which feeds a three-vertex window one vertex per cycle (n + 2 reads), followed by the
// drain of the six-stage term pipeline. Slots must be written before any test reads them.
module convex_polygon_point_test_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cppt_pkg::COUNT_BITS-1:0] cfg_data,
  cppt_in_if.sink                         items,
  cppt_out_if.source                      results
);
  import cppt_pkg::*;

  localparam int EW = TAG_BITS + 3 * COORD_BITS;

  logic [COUNT_BITS-1:0] vertex_count;
  logic                  push;
  logic [EW-1:0]         push_data;
  logic                  push_ready;
  logic                  q_valid;
  logic                  q_ready;
  logic [EW-1:0]         q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  cppt_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .items      (items),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  cppt_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (q_ready),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  cppt_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .results      (results)
  );

endmodule

>>> tb/convex_polygon_point_test_unit_test.sv
module convex_polygon_point_test_unit_test;
  import cppt_pkg::*;

  localparam int  N_SLOTS       = 16;
  localparam int  IDLE_PCT      = 22;
  localparam int  SETTLE_CYCLES = 48;
  localparam int  CYCLE_LIMIT   = 400000;
  localparam int  RANDOM_ITEMS  = 610;
  localparam real TWO_PI        = 6.283185307179586;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [15:0]  coord_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [COUNT_BITS-1:0] cfg_data;

  cppt_in_if #(.COORD_BITS(16)) items_if ();
  cppt_out_if                   results_if ();

  convex_polygon_point_test_unit #(
    .MAX_VERTICES(N_SLOTS),
    .COORD_BITS  (16)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .items   (items_if),
    .results (results_if)
  );

  coord_t                store_x [N_SLOTS];
  coord_t                store_y [N_SLOTS];
  coord_t                store_z [N_SLOTS];
  logic [COUNT_BITS-1:0] vertex_count_reg = VERTEX_COUNT_RESET;
  bit                    expected_inside [$];
  bit                    want_inside;
  int                    mismatches  = 0;
  int                    items_sent  = 0;
  int                    cycle_count = 0;
  bit                    idle_on     = 1'b1;

  int  poly_x [N_SLOTS];
  int  poly_y [N_SLOTS];
  int  poly_z [N_SLOTS];
  real ctr_x, ctr_y, ctr_z, norm_x, norm_y, norm_z;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_inside.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    results_if.ready <= !idle_on || $urandom_range(0, 99) >= IDLE_PCT;
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_inside.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no pending point test: inside_res=%0b",
                   results_if.inside_res);
      end else begin
        want_inside = expected_inside.pop_front();
        if (results_if.inside_res !== want_inside) begin
          mismatches++;
          if (mismatches <= 10)
            $display("inside_res mismatch: expected %0b, got %0b",
                     want_inside, results_if.inside_res);
        end
      end
    end
  end

  function automatic int used_vertices(logic [COUNT_BITS-1:0] reg_value);
    if (reg_value < MIN_VERTICES) return int'(MIN_VERTICES);
    if (reg_value > N_SLOTS) return N_SLOTS;
    return int'(reg_value);
  endfunction

  function automatic bit point_inside(coord_t px, coord_t py, coord_t pz);
    wide_t ux, uy, uz, ex, ey, ez, wx, wy, wz;
    wide_t c1x, c1y, c1z, c2x, c2y, c2z, dot;
    int    n, i, j, k;
    bit    outside;
    n = used_vertices(vertex_count_reg);
    outside = 1'b0;
    for (i = 0; i < n; i++) begin
      j = (i + 1) % n;
      k = (i + 2) % n;
      ux = store_x[k] - store_x[i];
      uy = store_y[k] - store_y[i];
      uz = store_z[k] - store_z[i];
      ex = store_x[j] - store_x[i];
      ey = store_y[j] - store_y[i];
      ez = store_z[j] - store_z[i];
      wx = px - store_x[i];
      wy = py - store_y[i];
      wz = pz - store_z[i];
      c1x = uy * ez - uz * ey;
      c1y = uz * ex - ux * ez;
      c1z = ux * ey - uy * ex;
      c2x = ey * wz - ez * wy;
      c2y = ez * wx - ex * wz;
      c2z = ex * wy - ey * wx;
      dot = c1x * c2x + c1y * c2y + c1z * c2z;
      if (dot > 0) outside = 1'b1;
    end
    return !outside;
  endfunction

  function automatic int clip16(real v);
    if (v > 32767.0) return 32767;
    if (v < -32768.0) return -32768;
    return $rtoi(v);
  endfunction

  function automatic real spread(int half);
    return real'($urandom_range(0, 2 * half)) - half;
  endfunction

  task automatic send_item(logic cmd, int slot, int x, int y, int z);
    logic [SLOT_BITS-1:0] slot_bits;
    slot_bits = SLOT_BITS'(slot);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid        <= 1'b1;
    items_if.command      <= cmd;
    items_if.vertex_index <= slot_bits;
    items_if.coord_x      <= coord_t'(x);
    items_if.coord_y      <= coord_t'(y);
    items_if.coord_z      <= coord_t'(z);
    do @(posedge clk); while (!items_if.ready);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      store_x[slot_bits] = coord_t'(x);
      store_y[slot_bits] = coord_t'(y);
      store_z[slot_bits] = coord_t'(z);
    end else begin
      expected_inside.push_back(point_inside(coord_t'(x), coord_t'(y), coord_t'(z)));
    end
  endtask

  task automatic wait_drained();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (expected_inside.size() != 0);
  endtask

  task automatic set_vertex_count(logic [COUNT_BITS-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_count_reg = value;
  endtask

  task automatic run_polygon_phase(logic [COUNT_BITS-1:0] reg_value, int queries);
    real ax, ay, az, bx, by, bz, len, proj, rad, ang, s, w1, w2, w3, qx, qy, qz;
    int  n, a, b, c, k, tmp, kind, bnd;
    int  order [N_SLOTS];
    set_vertex_count(reg_value);
    n = used_vertices(reg_value);
    ax = spread(1000);
    ay = spread(1000);
    az = spread(1000);
    len = $sqrt(ax * ax + ay * ay + az * az);
    if (len < 1.0) begin
      ax = 1.0; ay = 0.0; az = 0.0; len = 1.0;
    end
    ax = ax / len; ay = ay / len; az = az / len;
    bx = spread(1000);
    by = spread(1000);
    bz = spread(1000);
    proj = bx * ax + by * ay + bz * az;
    bx = bx - proj * ax; by = by - proj * ay; bz = bz - proj * az;
    len = $sqrt(bx * bx + by * by + bz * bz);
    if (len < 1.0) begin
      bx = -ay; by = ax; bz = 0.0;
      len = $sqrt(bx * bx + by * by);
      if (len < 1.0e-6) begin
        bx = 0.0; by = 1.0; len = 1.0;
      end
    end
    bx = bx / len; by = by / len; bz = bz / len;
    norm_x = ay * bz - az * by;
    norm_y = az * bx - ax * bz;
    norm_z = ax * by - ay * bx;

    tmp = $urandom_range(0, 99);
    if (tmp < 70) rad = $urandom_range(8, 300);
    else if (tmp < 90) rad = $urandom_range(300, 5000);
    else rad = $urandom_range(5000, 30000);
    bnd = 32765 - $rtoi(rad);
    ctr_x = spread(bnd);
    ctr_y = spread(bnd);
    ctr_z = spread(bnd);

    for (k = 0; k < n; k++) begin
      ang = TWO_PI * (k + 0.7 * $urandom_range(0, 999) / 1000.0) / n;
      poly_x[k] = clip16(ctr_x + rad * ($cos(ang) * ax + $sin(ang) * bx));
      poly_y[k] = clip16(ctr_y + rad * ($cos(ang) * ay + $sin(ang) * by));
      poly_z[k] = clip16(ctr_z + rad * ($cos(ang) * az + $sin(ang) * bz));
      order[k] = k;
    end
    for (k = n - 1; k > 0; k--) begin
      a = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[a];
      order[a] = tmp;
    end
    for (k = 0; k < n; k++)
      send_item(CMD_WRITE, order[k], poly_x[order[k]], poly_y[order[k]], poly_z[order[k]]);

    repeat (queries) begin
      kind = $urandom_range(0, 99);
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      c = $urandom_range(0, n - 1);
      w1 = $urandom_range(1, 100);
      w2 = $urandom_range(1, 100);
      w3 = $urandom_range(1, 100);
      qx = (w1 * poly_x[a] + w2 * poly_x[b] + w3 * poly_x[c]) / (w1 + w2 + w3);
      qy = (w1 * poly_y[a] + w2 * poly_y[b] + w3 * poly_y[c]) / (w1 + w2 + w3);
      qz = (w1 * poly_z[a] + w2 * poly_z[b] + w3 * poly_z[c]) / (w1 + w2 + w3);
      if (kind >= 34 && kind < 52) begin
        // land on an edge or a vertex, sometimes one step off
        b = (a + 1) % n;
        s = $urandom_range(0, 4) / 4.0;
        qx = poly_x[a] + s * (poly_x[b] - poly_x[a]);
        qy = poly_y[a] + s * (poly_y[b] - poly_y[a]);
        qz = poly_z[a] + s * (poly_z[b] - poly_z[a]);
        if ($urandom_range(0, 2) == 0) begin
          qx = qx + spread(1);
          qy = qy + spread(1);
          qz = qz + spread(1);
        end
      end else if (kind >= 52 && kind < 74) begin
        s = 1.05 + $urandom_range(0, 200) / 100.0;
        qx = ctr_x + s * (poly_x[a] - ctr_x);
        qy = ctr_y + s * (poly_y[a] - ctr_y);
        qz = ctr_z + s * (poly_z[a] - ctr_z);
      end else if (kind >= 74 && kind < 84) begin
        s = spread(2000);
        qx = qx + s * norm_x;
        qy = qy + s * norm_y;
        qz = qz + s * norm_z;
      end
      if (kind < 84) begin
        send_item(CMD_TEST, $urandom_range(0, 15), clip16(qx), clip16(qy), clip16(qz));
      end else if (kind < 92) begin
        send_item(CMD_TEST, $urandom_range(0, 15), $urandom, $urandom, $urandom);
      end else if (kind < 96) begin
        send_item(CMD_WRITE, $urandom_range(0, 15), $urandom, $urandom, $urandom);
      end else begin
        // hold off until every pending result is back
        wait_drained();
        send_item(CMD_TEST, $urandom_range(0, 15), clip16(qx), clip16(qy), clip16(qz));
      end
    end
  endtask

  task automatic test_fill_store();
    int k;
    send_item(CMD_WRITE, 0, -32768, -32768, -32768);
    send_item(CMD_WRITE, 1, 32767, -32768, 32767);
    send_item(CMD_WRITE, 2, -32768, 32767, 0);
    for (k = 3; k < N_SLOTS; k++)
      send_item(CMD_WRITE, k, $urandom, $urandom, $urandom);
    send_item(CMD_TEST, 15, 32767, 32767, 32767);
    send_item(CMD_TEST, 0, -32768, -32768, -32768);
    send_item(CMD_TEST, 7, 0, 0, 0);
  endtask

  task automatic test_count_limits();
    set_vertex_count(0);
    send_item(CMD_TEST, 3, -1, -1, -1);
    set_vertex_count(31);
    send_item(CMD_TEST, 9, 12345, -54, 3);
  endtask

  task automatic test_degenerate();
    set_vertex_count(3);
    send_item(CMD_WRITE, 2, 32767, -32768, 32767);
    send_item(CMD_TEST, 0, 0, 0, 0);
    send_item(CMD_TEST, 15, 32767, 32767, -32768);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    run_polygon_phase(16, 16);
    run_polygon_phase(3, 16);
    idle_on = 1'b1;
  endtask

  task automatic test_random_polygons(int target);
    int                    tmp;
    logic [COUNT_BITS-1:0] reg_value;
    while (items_sent < target) begin
      tmp = $urandom_range(0, 99);
      if (tmp < 65) reg_value = COUNT_BITS'($urandom_range(3, 8));
      else if (tmp < 80) reg_value = COUNT_BITS'(N_SLOTS);
      else if (tmp < 92) reg_value = COUNT_BITS'($urandom_range(9, 15));
      else if (tmp < 96) reg_value = COUNT_BITS'($urandom_range(0, 2));
      else reg_value = COUNT_BITS'($urandom_range(17, 31));
      run_polygon_phase(reg_value, $urandom_range(8, 20));
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_data              <= '0;
    items_if.valid        <= 1'b0;
    items_if.command      <= CMD_WRITE;
    items_if.vertex_index <= '0;
    items_if.coord_x      <= '0;
    items_if.coord_y      <= '0;
    items_if.coord_z      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_fill_store();
    test_count_limits();
    test_degenerate();
    test_full_rate();
    test_random_polygons(items_sent + RANDOM_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_inside.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> convex_polygon_point_test_unit.f
hdl/cppt_pkg.sv
hdl/cppt_if.sv
hdl/cppt_front.sv
hdl/cppt_queue.sv
hdl/cppt_term.sv
hdl/cppt_back.sv
hdl/convex_polygon_point_test_unit.sv
tb/convex_polygon_point_test_unit_test.sv
